FILE: rtl/core/mfsgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfsgd_pkg
// Types, widths and codes shared by the matrix factorization SGD trainer.
// ----------------------------------------------------------------------------
package mfsgd_pkg;

  localparam int NUM_USERS = 1024;
  localparam int NUM_ITEMS = 2048;
  localparam int FEATURES  = 32;

  localparam int FEAT_W  = $clog2(FEATURES);
  localparam int USER_W  = 10;
  localparam int ITEM_W  = 11;
  localparam int DATA_W  = 16;
  localparam int OUT_W   = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int FUNC_W  = 3;

  localparam int UADDR_W = USER_W + FEAT_W;
  localparam int IADDR_W = ITEM_W + FEAT_W;

  // Shared multiplier: wide signed operand times 17-bit signed operand.
  localparam int MUL_A_W = 37;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Dot product accumulator: FEATURES products of two Q4.12 values.
  localparam int ACC_W   = 2 * DATA_W + FEAT_W;
  localparam int PRED_W  = ACC_W + 1 - 12;
  // Gradient term err*other*16 - reg*own stays below 2^51 in magnitude.
  localparam int DELTA_W = 52;
  localparam int HI_W    = DELTA_W - 16;
  localparam int SUM_W   = MUL_P_W + 16 + 1;
  localparam int STEP_W  = SUM_W - 32;
  localparam int NEW_W   = STEP_W + 1;

  localparam logic [CFG_W-1:0] LR_RESET  = 16'd655;
  localparam logic [CFG_W-1:0] REG_RESET = 16'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_WEIGHT = 1'd1;

  localparam logic [FUNC_W-1:0] FN_TRAIN     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PREDICT   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LOAD_USER = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOAD_ITEM = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ_USER = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ_ITEM = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [USER_W-1:0]        user_index;
    logic [ITEM_W-1:0]        item_index;
    logic signed [DATA_W-1:0] target;
    logic [FEAT_W-1:0]        feature_index;
    logic signed [DATA_W-1:0] feature_value;
  } request_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]  prediction;
    logic signed [OUT_W-1:0]  error;
    logic signed [DATA_W-1:0] read_value;
  } result_t;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DOT,
    ST_PRED,
    ST_ERR,
    ST_RD,
    ST_EO,
    ST_RO,
    ST_DELTA,
    ST_HI,
    ST_LO,
    ST_STEP,
    ST_NEW,
    ST_WR
  } state_t;

  function automatic logic user_ok(input logic [USER_W-1:0] u);
    return int'(u) < NUM_USERS;
  endfunction

  function automatic logic item_ok(input logic [ITEM_W-1:0] i);
    return int'(i) < NUM_ITEMS;
  endfunction

  function automatic logic feat_ok(input logic [FEAT_W-1:0] f);
    return int'(f) < FEATURES;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mfsgd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfsgd_mul
// Shared signed multiplier with a registered product, used for the dot
// product and for every term of the feature update.
// ----------------------------------------------------------------------------
module mfsgd_mul (
  input  wire logic                              clk,
  input  wire mfsgd_pkg::mul_req_t               req,
  output logic signed [mfsgd_pkg::MUL_P_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/matrix_factorization_sgd_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_update
// Results: a load returns none; read, predict and train raise done
//   together with the result.
// Throughput: one request at a time; busy stays high until done. The dot
//   product streams one element a cycle; the update steps each element
//   through the single shared multiplier and the one-port tables.
// Reset: synchronous; sets the sequencer and both config registers to
//   defaults. Feature tables are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module matrix_factorization_sgd_update (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire mfsgd_pkg::request_t                   request,
  output logic                                       busy,
  output logic                                       done,
  output mfsgd_pkg::result_t                         result,
  input  wire logic                                  cfg_we,
  input  wire logic [mfsgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mfsgd_pkg::CFG_W-1:0]           cfg_data
);

  localparam int D  = mfsgd_pkg::DATA_W;
  localparam int O  = mfsgd_pkg::OUT_W;
  localparam int AW = mfsgd_pkg::MUL_A_W;
  localparam int PW = mfsgd_pkg::MUL_P_W;
  localparam int FW = mfsgd_pkg::FEAT_W;

  // Config
  logic [mfsgd_pkg::CFG_W-1:0] step_rate;
  logic [mfsgd_pkg::CFG_W-1:0] reg_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate  <= mfsgd_pkg::LR_RESET;
      reg_weight <= mfsgd_pkg::REG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfsgd_pkg::CFG_STEP_RATE:  step_rate  <= cfg_data;
        mfsgd_pkg::CFG_REG_WEIGHT: reg_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and control
  mfsgd_pkg::state_t   state, state_next;
  logic                done_next;
  mfsgd_pkg::result_t  result_next;
  logic [FW-1:0]       k;
  logic                side;
  logic                issue_done;
  logic                rd_v;
  logic                mul_v;
  logic                k_last;

  // Datapath registers
  mfsgd_pkg::request_t                     req;
  logic signed [mfsgd_pkg::ACC_W-1:0]      acc;
  logic signed [O-1:0]                     pred;
  logic signed [O-1:0]                     err;
  logic signed [PW-1:0]                    t1;
  logic signed [mfsgd_pkg::DELTA_W-1:0]    delta;
  logic signed [mfsgd_pkg::STEP_W-1:0]     step;
  logic signed [D-1:0]                     new_u;
  logic signed [D-1:0]                     new_v;

  // Tables
  logic signed [D-1:0] user_mem [2**mfsgd_pkg::UADDR_W];
  logic signed [D-1:0] item_mem [2**mfsgd_pkg::IADDR_W];
  logic [mfsgd_pkg::UADDR_W-1:0] u_addr;
  logic [mfsgd_pkg::IADDR_W-1:0] i_addr;
  logic                          u_re, u_we, i_re, i_we;
  logic signed [D-1:0]           u_wdata, i_wdata;
  logic signed [D-1:0]           u_q, v_q;

  // Shared multiplier
  mfsgd_pkg::mul_req_t   mul;
  logic signed [PW-1:0]  prod;

  mfsgd_mul u_mul (
    .clk  (clk),
    .req  (mul),
    .prod (prod)
  );

  assign busy   = (state != mfsgd_pkg::ST_IDLE);
  assign k_last = (k == FW'(mfsgd_pkg::FEATURES - 1));

  // Own and partner element for the side being updated
  logic signed [D-1:0] own, other;
  assign own   = side ? v_q : u_q;
  assign other = side ? u_q : v_q;

  // Arithmetic between registers
  logic [mfsgd_pkg::ACC_W:0]       rnd;
  logic signed [O-1:0]             pred_calc;
  logic signed [O:0]               diff;
  logic signed [O-1:0]             err_calc;
  logic [PW+3:0]                   grad;
  logic [mfsgd_pkg::SUM_W-1:0]     sum;
  logic signed [mfsgd_pkg::NEW_W-1:0] upd;
  logic signed [D-1:0]             new_calc;

  always_comb begin
    // round to 12 fraction bits; the shifted sum fits in 32 bits
    rnd       = {acc[mfsgd_pkg::ACC_W-1], acc} + (mfsgd_pkg::ACC_W + 1)'(2048);
    pred_calc = {{(O - mfsgd_pkg::PRED_W){rnd[mfsgd_pkg::ACC_W]}},
                 rnd[mfsgd_pkg::ACC_W:12]};

    diff = {req.target[D-1], {(O - D){req.target[D-1]}}, req.target} - {pred[O-1], pred};
    if (diff[O] != diff[O-1]) begin
      err_calc = diff[O] ? {1'b1, {(O-1){1'b0}}} : {1'b0, {(O-1){1'b1}}};
    end else begin
      err_calc = diff[O-1:0];
    end

    // err*other*16 - reg*own
    grad = {t1, 4'b0} - {{4{prod[PW-1]}}, prod};

    // (lr*hi)*2^16 + lr*lo + 2^31, floor shift by 32
    sum = {t1[PW-1], t1, 16'b0} + {{(mfsgd_pkg::SUM_W - 32){1'b0}}, prod[31:0]}
          + (mfsgd_pkg::SUM_W)'(64'h8000_0000);

    upd = {{(mfsgd_pkg::NEW_W - D){own[D-1]}}, own}
          + {step[mfsgd_pkg::STEP_W-1], step};
    if (upd > (mfsgd_pkg::NEW_W)'(32767)) begin
      new_calc = 16'sh7FFF;
    end else if (upd < -((mfsgd_pkg::NEW_W)'(32768))) begin
      new_calc = 16'sh8000;
    end else begin
      new_calc = upd[D-1:0];
    end
  end

  // Multiplier operand selection
  always_comb begin
    mul.en = 1'b0;
    mul.a  = '0;
    mul.b  = '0;
    unique case (state)
      mfsgd_pkg::ST_DOT: begin
        mul.en = rd_v;
        mul.a  = {{(AW - D){u_q[D-1]}}, u_q};
        mul.b  = {v_q[D-1], v_q};
      end
      mfsgd_pkg::ST_EO: begin
        mul.en = 1'b1;
        mul.a  = {{(AW - O){err[O-1]}}, err};
        mul.b  = {other[D-1], other};
      end
      mfsgd_pkg::ST_RO: begin
        mul.en = 1'b1;
        mul.a  = {{(AW - D){own[D-1]}}, own};
        mul.b  = {1'b0, reg_weight};
      end
      mfsgd_pkg::ST_HI: begin
        mul.en = 1'b1;
        mul.a  = {{(AW - mfsgd_pkg::HI_W){delta[mfsgd_pkg::DELTA_W-1]}},
                  delta[mfsgd_pkg::DELTA_W-1:16]};
        mul.b  = {1'b0, step_rate};
      end
      mfsgd_pkg::ST_LO: begin
        mul.en = 1'b1;
        mul.a  = {{(AW - 16){1'b0}}, delta[15:0]};
        mul.b  = {1'b0, step_rate};
      end
      default: ;
    endcase
  end

  // Table ports
  always_comb begin
    u_addr  = {req.user_index, k};
    i_addr  = {req.item_index, k};
    u_re    = 1'b0;
    i_re    = 1'b0;
    u_we    = 1'b0;
    i_we    = 1'b0;
    u_wdata = new_u;
    i_wdata = new_v;
    unique case (state)
      mfsgd_pkg::ST_IDLE: begin
        u_addr  = {request.user_index, request.feature_index};
        i_addr  = {request.item_index, request.feature_index};
        u_wdata = request.feature_value;
        i_wdata = request.feature_value;
        u_re    = start && (request.func == mfsgd_pkg::FN_READ_USER);
        i_re    = start && (request.func == mfsgd_pkg::FN_READ_ITEM);
        u_we    = start && (request.func == mfsgd_pkg::FN_LOAD_USER)
                  && mfsgd_pkg::user_ok(request.user_index)
                  && mfsgd_pkg::feat_ok(request.feature_index);
        i_we    = start && (request.func == mfsgd_pkg::FN_LOAD_ITEM)
                  && mfsgd_pkg::item_ok(request.item_index)
                  && mfsgd_pkg::feat_ok(request.feature_index);
      end
      mfsgd_pkg::ST_DOT: begin
        u_re = !issue_done;
        i_re = !issue_done;
      end
      mfsgd_pkg::ST_RD: begin
        u_re = 1'b1;
        i_re = 1'b1;
      end
      mfsgd_pkg::ST_WR: begin
        u_we = 1'b1;
        i_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (u_we) user_mem[u_addr] <= u_wdata;
    if (u_re) u_q <= user_mem[u_addr];
  end

  always_ff @(posedge clk) begin
    if (i_we) item_mem[i_addr] <= i_wdata;
    if (i_re) v_q <= item_mem[i_addr];
  end

  // Next state and result
  always_comb begin
    state_next  = state;
    done_next   = 1'b0;
    result_next = result;
    unique case (state)
      mfsgd_pkg::ST_IDLE: begin
        if (start) begin
          unique case (request.func) inside
            mfsgd_pkg::FN_TRAIN, mfsgd_pkg::FN_PREDICT: begin
              if (mfsgd_pkg::user_ok(request.user_index)
                  && mfsgd_pkg::item_ok(request.item_index)) begin
                state_next = mfsgd_pkg::ST_DOT;
              end else begin
                done_next   = 1'b1;
                result_next = '0;
              end
            end
            mfsgd_pkg::FN_READ_USER, mfsgd_pkg::FN_READ_ITEM: begin
              state_next = mfsgd_pkg::ST_READ;
            end
            default: ;
          endcase
        end
      end
      mfsgd_pkg::ST_READ: begin
        done_next   = 1'b1;
        result_next = '0;
        if (req.func == mfsgd_pkg::FN_READ_USER) begin
          if (mfsgd_pkg::user_ok(req.user_index) && mfsgd_pkg::feat_ok(req.feature_index)) begin
            result_next.read_value = u_q;
          end
        end else begin
          if (mfsgd_pkg::item_ok(req.item_index) && mfsgd_pkg::feat_ok(req.feature_index)) begin
            result_next.read_value = v_q;
          end
        end
        state_next = mfsgd_pkg::ST_IDLE;
      end
      mfsgd_pkg::ST_DOT: begin
        if (issue_done && !rd_v && !mul_v) state_next = mfsgd_pkg::ST_PRED;
      end
      mfsgd_pkg::ST_PRED: state_next = mfsgd_pkg::ST_ERR;
      mfsgd_pkg::ST_ERR: begin
        if (req.func == mfsgd_pkg::FN_PREDICT) begin
          done_next              = 1'b1;
          result_next            = '0;
          result_next.prediction = pred;
          state_next             = mfsgd_pkg::ST_IDLE;
        end else begin
          state_next = mfsgd_pkg::ST_RD;
        end
      end
      mfsgd_pkg::ST_RD:    state_next = mfsgd_pkg::ST_EO;
      mfsgd_pkg::ST_EO:    state_next = mfsgd_pkg::ST_RO;
      mfsgd_pkg::ST_RO:    state_next = mfsgd_pkg::ST_DELTA;
      mfsgd_pkg::ST_DELTA: state_next = mfsgd_pkg::ST_HI;
      mfsgd_pkg::ST_HI:    state_next = mfsgd_pkg::ST_LO;
      mfsgd_pkg::ST_LO:    state_next = mfsgd_pkg::ST_STEP;
      mfsgd_pkg::ST_STEP:  state_next = mfsgd_pkg::ST_NEW;
      mfsgd_pkg::ST_NEW:   state_next = side ? mfsgd_pkg::ST_WR : mfsgd_pkg::ST_EO;
      mfsgd_pkg::ST_WR: begin
        if (k_last) begin
          done_next              = 1'b1;
          result_next            = '0;
          result_next.prediction = pred;
          result_next.error      = err;
          state_next             = mfsgd_pkg::ST_IDLE;
        end else begin
          state_next = mfsgd_pkg::ST_RD;
        end
      end
      default: state_next = mfsgd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfsgd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
    result <= result_next;
  end

  // Element counter and dot product pipeline flags
  always_ff @(posedge clk) begin
    if (rst) begin
      k          <= '0;
      side       <= 1'b0;
      issue_done <= 1'b0;
      rd_v       <= 1'b0;
      mul_v      <= 1'b0;
    end else begin
      unique case (state)
        mfsgd_pkg::ST_IDLE: begin
          k          <= '0;
          side       <= 1'b0;
          issue_done <= 1'b0;
          rd_v       <= 1'b0;
          mul_v      <= 1'b0;
        end
        mfsgd_pkg::ST_DOT: begin
          rd_v  <= !issue_done;
          mul_v <= rd_v;
          if (!issue_done) begin
            k <= k + 1'b1;
            if (k_last) issue_done <= 1'b1;
          end
        end
        mfsgd_pkg::ST_PRED: k <= '0;
        mfsgd_pkg::ST_NEW:  side <= !side;
        mfsgd_pkg::ST_WR:   k <= k + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      mfsgd_pkg::ST_IDLE: begin
        if (start) begin
          req <= request;
          acc <= '0;
        end
      end
      mfsgd_pkg::ST_DOT: begin
        if (mul_v) acc <= acc + prod[mfsgd_pkg::ACC_W-1:0];
      end
      mfsgd_pkg::ST_PRED:  pred  <= pred_calc;
      mfsgd_pkg::ST_ERR:   err   <= err_calc;
      mfsgd_pkg::ST_RO:    t1    <= prod;
      mfsgd_pkg::ST_DELTA: delta <= grad[mfsgd_pkg::DELTA_W-1:0];
      mfsgd_pkg::ST_LO:    t1    <= prod;
      mfsgd_pkg::ST_STEP:  step  <= sum[mfsgd_pkg::SUM_W-1:32];
      mfsgd_pkg::ST_NEW: begin
        if (side) begin
          new_v <= new_calc;
        end else begin
          new_u <= new_calc;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
